// File: sv/bdq_pkg.sv
// Shared types and constants for the byte deque packet buffer.
// Holds the command codes, the request/response payload structs and pointer helpers.
package bdq_pkg;

   localparam int DEPTH  = 64;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = PTR_W + 1;
   localparam int BYTE_W = 8;
   localparam int CMD_W  = 3;
   localparam int AMT_W  = 8;
   localparam int FILL_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR      = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_PUSH_FRONT = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_POP_FRONT  = 3'd4,
      CMD_ERASE      = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] data_byte;
      logic [AMT_W-1:0]  amount;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] popped_byte;
      logic              error_flag;
      logic [FILL_W-1:0] fill_level;
   } rsp_type;

   // storage access for one command
   typedef struct packed {
      logic              we;
      logic              re;
      logic [PTR_W-1:0]  addr;
      logic [BYTE_W-1:0] wdata;
   } mem_op_type;

   // state seen after one command
   typedef struct packed {
      logic             pop_ok;
      logic             error;
      logic [CNT_W-1:0] count;
   } status_type;

   // fold a sum below twice the depth back into the ring
   function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0] r;
      r = (v >= SUM_W'(DEPTH)) ? v - SUM_W'(DEPTH) : v;
      return r[PTR_W-1:0];
   endfunction

endpackage

// File: sv/byte_deque_packet_buffer_unit.sv
// Top level of the byte deque packet buffer: request register, control, storage, response register.
// Depends on bdq_pkg, bdq_ctrl and bdq_store.

// A bounded deque of up to 64 bytes kept in a circular store. Every request
// (clear, push back, push front, pop back, pop front, erase front) yields
// exactly one response carrying the popped byte, the sticky error flag and the
// fill level after that command. One request is taken each cycle when the
// response side keeps up. A command passes from the request register, which
// feeds the pointer update and the single storage port, to the registered
// results (status and read data), which are captured when the command advances.
// Commands are processed strictly in order, so a pop sees every earlier push.
module byte_deque_packet_buffer_unit import bdq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic              req_valid_ff;
   req_type           req_ff;
   logic              rsp_valid_ff;
   logic              pop_ok_ff;
   logic              error_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              advance;
   mem_op_type        mem_op;
   status_type        status;
   logic [BYTE_W-1:0] rd_data;

   assign advance   = req_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~req_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready & req_valid) begin
         req_ff <= req_payload;
      end
   end

   bdq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cmd_req (req_ff),
      .mem_op  (mem_op),
      .status  (status)
   );

   bdq_store u_store (
      .clock   (clock),
      .mem_op  (mem_op),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pop_ok_ff <= status.pop_ok;
         error_ff  <= status.error;
         count_ff  <= status.count;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_payload.popped_byte = pop_ok_ff ? rd_data : '0;
   assign rsp_payload.error_flag  = error_ff;
   assign rsp_payload.fill_level  = FILL_W'(count_ff);

endmodule

// File: sv/bdq_ctrl.sv
// Command decode and ring pointer state for the byte deque.
// Keeps front pointer, byte count and sticky error; depends on bdq_pkg.
module bdq_ctrl import bdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  req_type     cmd_req,
   output mem_op_type  mem_op,
   output status_type  status
);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             error_ff, error_in;

   logic [SUM_W-1:0] head_ext;
   logic [SUM_W-1:0] count_ext;
   logic [SUM_W-1:0] count_dec;
   logic             not_full;
   logic             not_empty;
   logic             erase_ok;
   logic             pop_ok;

   always_comb begin
      head_ext  = SUM_W'(head_ff);
      count_ext = SUM_W'(count_ff);
      count_dec = count_ext - SUM_W'(1);
      not_full  = (count_ff < CNT_W'(DEPTH));
      not_empty = (count_ff != '0);
      erase_ok  = ((AMT_W + 1)'(count_ff) >= (AMT_W + 1)'(cmd_req.amount));

      head_in      = head_ff;
      count_in     = count_ff;
      error_in     = error_ff;
      pop_ok       = 1'b0;
      mem_op.we    = 1'b0;
      mem_op.re    = 1'b0;
      mem_op.addr  = head_ff;
      mem_op.wdata = cmd_req.data_byte;

      case (cmd_req.command)
         CMD_CLEAR: begin
            head_in  = '0;
            count_in = '0;
            error_in = 1'b0;
         end
         CMD_PUSH_BACK: begin
            if (not_full) begin
               mem_op.we   = 1'b1;
               mem_op.addr = wrap_ptr(head_ext + count_ext);
               count_in    = count_ff + CNT_W'(1);
            end else begin
               error_in = 1'b1;
            end
         end
         CMD_PUSH_FRONT: begin
            if (not_full) begin
               head_in     = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - PTR_W'(1);
               mem_op.we   = 1'b1;
               mem_op.addr = head_in;
               count_in    = count_ff + CNT_W'(1);
            end else begin
               error_in = 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (not_empty) begin
               mem_op.re   = 1'b1;
               mem_op.addr = wrap_ptr(head_ext + count_dec);
               count_in    = count_ff - CNT_W'(1);
               pop_ok      = 1'b1;
            end else begin
               error_in = 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (not_empty) begin
               mem_op.re   = 1'b1;
               mem_op.addr = head_ff;
               head_in     = wrap_ptr(head_ext + SUM_W'(1));
               count_in    = count_ff - CNT_W'(1);
               pop_ok      = 1'b1;
            end else begin
               error_in = 1'b1;
            end
         end
         CMD_ERASE: begin
            if (erase_ok) begin
               // amount is at most the count here, so it fits the pointer sum
               head_in  = wrap_ptr(head_ext + SUM_W'(cmd_req.amount));
               count_in = count_ff - CNT_W'(cmd_req.amount);
            end else begin
               error_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // act only on the cycle the command moves to the result stage
      mem_op.we = mem_op.we & advance;
      mem_op.re = mem_op.re & advance;

      status.pop_ok = pop_ok;
      status.error  = error_in;
      status.count  = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         error_ff <= 1'b0;
      end else if (advance) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         error_ff <= error_in;
      end
   end

endmodule

// File: sv/bdq_store.sv
// Byte storage ring for the byte deque: one write or one registered read per cycle.
// Depends on bdq_pkg for the access struct and depth.
module bdq_store import bdq_pkg::*; (
   input  logic              clock,
   input  mem_op_type        mem_op,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_op.we) begin
         mem[mem_op.addr] <= mem_op.wdata;
      end
   end

   // hold the read data while the result stage stalls
   always_ff @(posedge clock) begin
      if (mem_op.re) begin
         rd_data_ff <= mem[mem_op.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
